FILE: hw/rtl/hpbfc_pkg.sv
package hpbfc_pkg;

    localparam int MAX_BURST_LEN = 64;
    localparam int LEN_W = 7;
    localparam int HEAD_DEPTH = 5;
    localparam int TAIL_DEPTH = 10;
    localparam int CFG_INDEX_W = 1;
    localparam int TEMP_W = 6;

    localparam logic [7:0] IDLE_BYTE = 8'h01;
    localparam logic [7:0] HB_BYTE_OFF = 8'h04;
    localparam logic [7:0] HB_BYTE_ON = 8'h0C;
    localparam logic [7:0] ACK_BYTE_A = 8'hF1;
    localparam logic [7:0] ACK_BYTE_B = 8'hD5;
    localparam logic [7:0] MODE_HEAT_A = 8'h6C;
    localparam logic [7:0] MODE_HEAT_B = 8'h64;
    localparam logic [7:0] MODE_AUTO_BYTE = 8'h54;
    localparam logic [7:0] MODE_COOL_BYTE = 8'h5C;
    localparam logic [7:0] FLOOD_BYTE = 8'h40;
    localparam logic [7:0] FILL_BYTE = 8'hFF;
    localparam logic [7:0] HEAD_ZERO = 8'h00;
    localparam logic [7:0] HEAD_HALF = 8'h80;

    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_LOW = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TEMP_HIGH = 1'd1;
    localparam logic [TEMP_W-1:0] TEMP_LOW_RESET = 6'd5;
    localparam logic [TEMP_W-1:0] TEMP_HIGH_RESET = 6'd45;

    localparam logic [3:0] KIND_HEARTBEAT = 4'd0;
    localparam logic [3:0] KIND_ACK = 4'd1;
    localparam logic [3:0] KIND_SENSOR = 4'd2;
    localparam logic [3:0] KIND_ERROR_TAIL = 4'd3;
    localparam logic [3:0] KIND_STATE = 4'd4;
    localparam logic [3:0] KIND_SHORT = 4'd5;
    localparam logic [3:0] KIND_FLOOD = 4'd6;
    localparam logic [3:0] KIND_ISO_SHORT = 4'd7;
    localparam logic [3:0] KIND_ISO_TAIL = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN = 4'd9;

    localparam logic [1:0] MODE_COOL = 2'd0;
    localparam logic [1:0] MODE_AUTO = 2'd1;
    localparam logic [1:0] MODE_HEAT = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    localparam logic [2:0] FLAG_REMOTE_POWER = 3'b100;

    localparam logic [TEMP_W-1:0] SETPOINT_MIN = 6'd15;
    localparam logic [TEMP_W-1:0] SETPOINT_MAX = 6'd40;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } bus_item_t;

    typedef struct packed {
        logic [3:0]        frame_kind;
        logic [TEMP_W-1:0] inlet_temp;
        logic [TEMP_W-1:0] outlet_temp;
        logic [TEMP_W-1:0] air_temp;
        logic [TEMP_W-1:0] pipe_temp;
        logic [TEMP_W-1:0] vapour_temp;
        logic [2:0]        status_flags;
        logic              sensors_valid;
        logic [TEMP_W-1:0] sp_request;
        logic [TEMP_W-1:0] sp_confirm;
        logic              confirmed_valid;
        logic [1:0]        mode;
    } frame_item_t;

    function automatic logic [TEMP_W-1:0] dec1(input logic [7:0] x);
        logic [7:0] inv;
        inv = ~x;
        return inv[6:1];
    endfunction

    function automatic logic [TEMP_W-1:0] dec3(input logic [7:0] x);
        logic [7:0] inv;
        inv = ~x;
        return {1'b0, inv[7:3]};
    endfunction

    function automatic logic [1:0] mode_of(input logic [7:0] b);
        logic [1:0] m;
        case (b)
            MODE_HEAT_A:    m = MODE_HEAT;
            MODE_HEAT_B:    m = MODE_HEAT;
            MODE_AUTO_BYTE: m = MODE_AUTO;
            MODE_COOL_BYTE: m = MODE_COOL;
            default:        m = MODE_NONE;
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/heat_pump_bus_frame_classifier.sv
// Latency: an accepted closing item (idle byte or silence) ending a burst of three or
// more bytes alone gives a result, held in the output register from the next cycle on.
// Throughput: one item per cycle, set by the single classify stage between the burst
// registers and the result register; input stalls only while a result waits and the
// open burst already holds three or more bytes.
// Reset: burst length, output valid and the range registers are cleared or preset.
module heat_pump_bus_frame_classifier (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 bus_valid,
    output logic                                 bus_ready,
    input  hpbfc_pkg::bus_item_t                 bus_item,
    output logic                                 frame_valid,
    input  logic                                 frame_ready,
    output hpbfc_pkg::frame_item_t               frame_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [hpbfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hpbfc_pkg::TEMP_W-1:0]         cfg_data
);

    logic [7:0]                   head_reg [hpbfc_pkg::HEAD_DEPTH];
    logic [7:0]                   tail_reg [hpbfc_pkg::TAIL_DEPTH];
    logic [hpbfc_pkg::LEN_W-1:0]  len_reg;
    logic [hpbfc_pkg::LEN_W-1:0]  len_next;
    logic [hpbfc_pkg::TEMP_W-1:0] temp_low_reg;
    logic [hpbfc_pkg::TEMP_W-1:0] temp_high_reg;
    logic                         frame_valid_reg;
    logic                         frame_valid_next;
    hpbfc_pkg::frame_item_t       frame_item_reg;
    hpbfc_pkg::frame_item_t       frame_item_next;

    logic bus_accept;
    logic closing;
    logic can_emit;
    logic emit;
    logic store_byte;

    logic ff1;
    logic ff2;
    logic ff4;
    logic hb12;
    logic hb11;
    logic ack_hit;
    logic head_sensor;
    logic [7:0] h0;

    logic [hpbfc_pkg::TEMP_W-1:0] wi7;
    logic [hpbfc_pkg::TEMP_W-1:0] wo7;
    logic [hpbfc_pkg::TEMP_W-1:0] wi9;
    logic [hpbfc_pkg::TEMP_W-1:0] wo9;
    logic                         valid7;
    logic                         valid9;
    logic [7:0]                   inv3;
    logic [hpbfc_pkg::TEMP_W-1:0] sp_sensor;

    assign can_emit = (len_reg >= hpbfc_pkg::LEN_W'(3));
    assign bus_ready = !frame_valid_reg || frame_ready || !can_emit;
    assign bus_accept = bus_valid && bus_ready;
    assign closing = bus_item.action || (bus_item.rx_byte == hpbfc_pkg::IDLE_BYTE);
    assign emit = bus_accept && closing && can_emit;
    assign store_byte = bus_accept && !closing
        && (len_reg < hpbfc_pkg::LEN_W'(hpbfc_pkg::MAX_BURST_LEN));
    assign cfg_ready = 1'b1;
    assign frame_valid = frame_valid_reg;
    assign frame_item = frame_item_reg;

    always_comb
    begin
        len_next = len_reg;
        if (bus_accept)
        begin
            if (store_byte)
            begin
                len_next = len_reg + hpbfc_pkg::LEN_W'(1);
            end
            else
            begin
                len_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            temp_low_reg <= hpbfc_pkg::TEMP_LOW_RESET;
            temp_high_reg <= hpbfc_pkg::TEMP_HIGH_RESET;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            frame_valid_reg <= frame_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    hpbfc_pkg::REG_TEMP_LOW:  temp_low_reg <= cfg_data;
                    hpbfc_pkg::REG_TEMP_HIGH: temp_high_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // The head keeps the first bytes of the burst; the tail holds the newest byte first.
    always_ff @(posedge clk)
    begin
        if (store_byte)
        begin
            for (int i = 0; i < hpbfc_pkg::HEAD_DEPTH; i++)
            begin
                if (len_reg == hpbfc_pkg::LEN_W'(i))
                begin
                    head_reg[i] <= bus_item.rx_byte;
                end
            end
            tail_reg[0] <= bus_item.rx_byte;
            for (int i = 1; i < hpbfc_pkg::TAIL_DEPTH; i++)
            begin
                tail_reg[i] <= tail_reg[i-1];
            end
        end
        if (emit)
        begin
            frame_item_reg <= frame_item_next;
        end
    end

    always_comb
    begin
        frame_valid_next = frame_valid_reg;
        if (emit)
        begin
            frame_valid_next = 1'b1;
        end
        else if (frame_ready)
        begin
            frame_valid_next = 1'b0;
        end
    end

    assign h0 = head_reg[0];
    assign ff1 = (tail_reg[0] == hpbfc_pkg::FILL_BYTE);
    assign ff2 = (tail_reg[1] == hpbfc_pkg::FILL_BYTE);
    assign ff4 = (len_reg >= hpbfc_pkg::LEN_W'(4)) && (tail_reg[3] == hpbfc_pkg::FILL_BYTE);
    assign hb12 = (len_reg == hpbfc_pkg::LEN_W'(12))
        && ((head_reg[1] == hpbfc_pkg::HB_BYTE_OFF) || (head_reg[1] == hpbfc_pkg::HB_BYTE_ON))
        && (head_reg[2] == hpbfc_pkg::FILL_BYTE);
    assign hb11 = (len_reg == hpbfc_pkg::LEN_W'(11))
        && ((h0 == hpbfc_pkg::HB_BYTE_OFF) || (h0 == hpbfc_pkg::HB_BYTE_ON))
        && (head_reg[1] == hpbfc_pkg::FILL_BYTE);
    assign ack_hit = ((len_reg >= hpbfc_pkg::LEN_W'(7)) && (len_reg <= hpbfc_pkg::LEN_W'(13))
            && (head_reg[1] == hpbfc_pkg::ACK_BYTE_A) && (head_reg[3] == hpbfc_pkg::ACK_BYTE_B))
        || ((len_reg >= hpbfc_pkg::LEN_W'(6)) && (len_reg <= hpbfc_pkg::LEN_W'(13))
            && (h0 == hpbfc_pkg::ACK_BYTE_A) && (head_reg[2] == hpbfc_pkg::ACK_BYTE_B));
    assign head_sensor = (h0 == hpbfc_pkg::FILL_BYTE) || (h0 == hpbfc_pkg::HEAD_ZERO)
        || (h0 == hpbfc_pkg::HEAD_HALF);

    assign wi7 = hpbfc_pkg::dec3(tail_reg[6]);
    assign wo7 = hpbfc_pkg::dec1(tail_reg[2]);
    assign wi9 = hpbfc_pkg::dec3(tail_reg[8]);
    assign wo9 = hpbfc_pkg::dec1(tail_reg[4]);
    assign valid7 = (wi7 >= temp_low_reg) && (wi7 <= temp_high_reg)
        && (wo7 >= temp_low_reg) && (wo7 <= temp_high_reg);
    assign valid9 = (wi9 >= temp_low_reg) && (wi9 <= temp_high_reg)
        && (wo9 >= temp_low_reg) && (wo9 <= temp_high_reg);
    assign inv3 = ~tail_reg[2];
    assign sp_sensor = hpbfc_pkg::dec3((h0 == hpbfc_pkg::FILL_BYTE) ? head_reg[3] : head_reg[2]);

    always_comb
    begin
        frame_item_next = '0;
        frame_item_next.mode = hpbfc_pkg::MODE_NONE;
        if (hb12 || hb11)
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_HEARTBEAT;
            frame_item_next.sp_request =
                hpbfc_pkg::dec1(hb12 ? head_reg[4] : head_reg[3]);
            frame_item_next.sp_confirm =
                hpbfc_pkg::dec1(hb12 ? head_reg[3] : head_reg[2]);
            frame_item_next.confirmed_valid = 1'b1;
            if ((hb12 ? head_reg[1] : h0) == hpbfc_pkg::HB_BYTE_ON)
            begin
                frame_item_next.status_flags = hpbfc_pkg::FLAG_REMOTE_POWER;
            end
        end
        else if (ack_hit)
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_ACK;
        end
        else if (head_sensor)
        begin
            if ((len_reg >= hpbfc_pkg::LEN_W'(9)) && ff1 && ff2 && ff4)
            begin
                frame_item_next.frame_kind = hpbfc_pkg::KIND_SENSOR;
                frame_item_next.inlet_temp = wi9;
                frame_item_next.outlet_temp = wo9;
                frame_item_next.air_temp = hpbfc_pkg::dec1(tail_reg[7]);
                frame_item_next.pipe_temp = hpbfc_pkg::dec1(tail_reg[6]);
                frame_item_next.vapour_temp = hpbfc_pkg::dec1(tail_reg[5]);
                frame_item_next.sensors_valid = valid9;
                frame_item_next.status_flags = {1'b0, inv3[1], inv3[4]};
                if (len_reg >= hpbfc_pkg::LEN_W'(24))
                begin
                    frame_item_next.mode = hpbfc_pkg::mode_of(tail_reg[9]);
                    if ((sp_sensor >= hpbfc_pkg::SETPOINT_MIN)
                        && (sp_sensor <= hpbfc_pkg::SETPOINT_MAX))
                    begin
                        frame_item_next.sp_confirm = sp_sensor;
                        frame_item_next.confirmed_valid = 1'b1;
                    end
                end
            end
            else if ((len_reg >= hpbfc_pkg::LEN_W'(7)) && (len_reg <= hpbfc_pkg::LEN_W'(12))
                && ff1 && ff2)
            begin
                frame_item_next.frame_kind = hpbfc_pkg::KIND_ERROR_TAIL;
                frame_item_next.inlet_temp = wi7;
                frame_item_next.outlet_temp = wo7;
                frame_item_next.air_temp = hpbfc_pkg::dec1(tail_reg[5]);
                frame_item_next.pipe_temp = hpbfc_pkg::dec1(tail_reg[4]);
                frame_item_next.vapour_temp = hpbfc_pkg::dec1(tail_reg[3]);
                frame_item_next.sensors_valid = valid7;
            end
            else
            begin
                frame_item_next.frame_kind = hpbfc_pkg::KIND_STATE;
                if (len_reg >= hpbfc_pkg::LEN_W'(15))
                begin
                    frame_item_next.mode = hpbfc_pkg::mode_of(tail_reg[0]);
                end
            end
        end
        else if (len_reg <= hpbfc_pkg::LEN_W'(4))
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_SHORT;
        end
        else if (h0 == hpbfc_pkg::FLOOD_BYTE)
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_FLOOD;
        end
        else if ((len_reg == hpbfc_pkg::LEN_W'(7)) && ff1 && ff2 && valid7)
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_ISO_SHORT;
            frame_item_next.inlet_temp = wi7;
            frame_item_next.outlet_temp = wo7;
            frame_item_next.air_temp = hpbfc_pkg::dec1(tail_reg[5]);
            frame_item_next.pipe_temp = hpbfc_pkg::dec1(tail_reg[4]);
            frame_item_next.vapour_temp = hpbfc_pkg::dec1(tail_reg[3]);
            frame_item_next.sensors_valid = 1'b1;
        end
        else if ((len_reg == hpbfc_pkg::LEN_W'(9)) && ff1 && ff2 && ff4)
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_ISO_TAIL;
            frame_item_next.inlet_temp = wi9;
            frame_item_next.outlet_temp = wo9;
            frame_item_next.air_temp = hpbfc_pkg::dec1(tail_reg[7]);
            frame_item_next.pipe_temp = hpbfc_pkg::dec1(tail_reg[6]);
            frame_item_next.vapour_temp = hpbfc_pkg::dec1(tail_reg[5]);
            frame_item_next.sensors_valid = valid9;
            frame_item_next.status_flags = {1'b0, inv3[1], inv3[4]};
        end
        else
        begin
            frame_item_next.frame_kind = hpbfc_pkg::KIND_UNKNOWN;
        end
    end

`ifndef SYNTHESIS
    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= hpbfc_pkg::LEN_W'(hpbfc_pkg::MAX_BURST_LEN))
        else $error("Burst length exceeds the buffer limit.");

    a_result_from_close: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_valid) |-> $past(bus_valid && bus_ready && closing
            && (len_reg >= hpbfc_pkg::LEN_W'(3))))
        else $error("A result appeared without a closed burst.");

    a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
        !bus_ready |-> (frame_valid && !frame_ready && (len_reg >= hpbfc_pkg::LEN_W'(3))))
        else $error("Input stalled without a waiting result.");

    a_close_clears_len: assert property (@(posedge clk) disable iff (!rst_n)
        (bus_valid && bus_ready && closing) |=> (len_reg == '0))
        else $error("Burst length not cleared after a closing item.");
`endif

endmodule
